[rtl/core/lfla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfla_pkg;

  localparam int unsigned TIME_W      = 31;
  localparam int unsigned AMOUNT_W    = 32;
  localparam int unsigned REL_W       = 32;
  localparam int unsigned TOTAL_W     = 64;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned IDX_OUT_W   = 6;
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // request data shared by every cell
  typedef struct packed {
    logic                free;    // retire expired leases this cycle
    logic [TIME_W-1:0]   now;
    logic [AMOUNT_W-1:0] amount;
    logic [REL_W-1:0]    rel;     // release time for a new grant
  } bcast_t;

  // per-cell outcome while it holds the search token
  typedef struct packed {
    logic               hit;      // free entry taken here
    logic               miss;     // last active entry and still busy
    logic [TOTAL_W-1:0] total;    // new total, zero unless hit
  } cell_res_t;

endpackage

`default_nettype wire

[rtl/core/lfla_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfla_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lfla_pkg::bcast_t    bcast_i,
  input  wire                 tok_i,     // token from left neighbor
  input  wire                 is_last_i, // highest entry in use
  output logic                tok_o,     // token sits here
  output logic                pass_o,    // token moves right
  output lfla_pkg::cell_res_t res_o
);
  import lfla_pkg::*;

  logic               tok_q;
  logic               busy_q, busy_d;
  logic [REL_W-1:0]   rel_q, rel_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W-1:0] sum;
  logic               grant;
  logic               expire;

  assign sum    = total_q + TOTAL_W'(bcast_i.amount);
  assign grant  = tok_q & ~busy_q;
  assign expire = bcast_i.free & busy_q & (rel_q <= {1'b0, bcast_i.now});

  always_comb begin
    busy_d  = busy_q;
    rel_d   = rel_q;
    total_d = total_q;
    if (expire) begin
      busy_d = 1'b0;
    end
    if (grant) begin
      busy_d  = 1'b1;
      rel_d   = bcast_i.rel;
      total_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      busy_q  <= 1'b0;
      total_q <= '0;
    end else begin
      tok_q   <= tok_i;
      busy_q  <= busy_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q <= rel_d;
  end

  assign tok_o      = tok_q;
  assign pass_o     = tok_q & busy_q & ~is_last_i;
  assign res_o.hit  = grant;
  assign res_o.miss = tok_q & busy_q & is_last_i;
  assign res_o.total = grant ? sum : '0;

endmodule

`default_nettype wire

[rtl/core/lowest_free_lease_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lowest-free lease allocator. A request (start high while busy is low)
// first retires, in every entry at once, each lease whose release time is
// at or before request_time_i; then a search token walks a row of entry
// cells from index 0 upward, one cell per cycle, and the first free entry
// takes the word: its total grows by amount_i (mod 2^64) and it stays
// leased until request_time_i + hold_duration_i. The result is shown for
// exactly one cycle with done_o; there is no back-pressure, so the
// receiver must take it then. A grant at index k raises done_o, via the
// result register, after the token walks cells 0 to k; if every entry
// in use is leased, done_o (granted_o low, index and total zero) follows
// the token into the last entry in use. busy is high while the token is
// in the row and drops in the done_o cycle, when the next request may be
// taken. num_entries (cfg_wdata_i, written on cfg_we_i; the user must
// write it only while idle, the block does not check) is clamped to
// 1..MAX_ENTRIES; leases above it still expire but are never granted.
module lowest_free_lease_allocator_top #(
  parameter int unsigned MAX_ENTRIES = lfla_pkg::MAX_ENTRIES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire  [lfla_pkg::TIME_W-1:0]    request_time_i,
  input  wire  [lfla_pkg::AMOUNT_W-1:0]  amount_i,
  input  wire  [lfla_pkg::TIME_W-1:0]    hold_duration_i,
  input  wire                            cfg_we_i,
  input  wire  [lfla_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic                           granted_o,
  output logic [lfla_pkg::IDX_OUT_W-1:0] entry_index_o,
  output logic [lfla_pkg::TOTAL_W-1:0]   entry_total_o
);
  import lfla_pkg::*;

  // width wide enough for both the register and the entry count
  localparam int unsigned CNT_W0 = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CNT_W  = (CNT_W0 > CFG_W) ? CNT_W0 : CFG_W;
  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned SEL_W  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

  logic                 accept;
  logic [CFG_W-1:0]     cfg_q;
  logic [CNT_W-1:0]     cfg_ext, cnt, last_idx;
  logic [AMOUNT_W-1:0]  amt_q;
  logic [REL_W-1:0]     rel_q;
  bcast_t               bcast;

  logic [MAX_ENTRIES-1:0] tok_vec, pass_vec, tok_in, is_last;
  cell_res_t              res [MAX_ENTRIES];

  logic                 hit_any, miss_any;
  logic [SEL_W-1:0]     hit_idx;
  logic [TOTAL_W-1:0]   hit_total;

  logic                 done_q, granted_q;
  logic [IDX_OUT_W-1:0] idx_q;
  logic [TOTAL_W-1:0]   total_q;

  assign busy   = |tok_vec;
  assign accept = start & ~busy;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign cfg_ext = CNT_W'(cfg_q);

  always_comb begin
    priority if (cfg_ext == '0) begin
      cnt = CNT_W'(1);
    end else if (cfg_ext > CNT_W'(MAX_ENTRIES)) begin
      cnt = CNT_W'(MAX_ENTRIES);
    end else begin
      cnt = cfg_ext;
    end
  end

  assign last_idx = cnt - CNT_W'(1);

  // ---- request word held for the walk ----
  always_ff @(posedge clk_i) begin
    if (accept) begin
      amt_q <= amount_i;
      rel_q <= REL_W'({1'b0, request_time_i}) + REL_W'({1'b0, hold_duration_i});
    end
  end

  assign bcast.free   = accept;
  assign bcast.now    = request_time_i;
  assign bcast.amount = amt_q;
  assign bcast.rel    = rel_q;

  // ---- row of entry cells ----
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = accept;
    end else begin : g_link
      assign tok_in[i] = pass_vec[i-1];
    end
    assign is_last[i] = (last_idx == CNT_W'(i));

    lfla_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bcast_i   (bcast),
      .tok_i     (tok_in[i]),
      .is_last_i (is_last[i]),
      .tok_o     (tok_vec[i]),
      .pass_o    (pass_vec[i]),
      .res_o     (res[i])
    );
  end

  // only the token holder can report, so an OR gathers the outcome
  always_comb begin
    hit_any   = 1'b0;
    miss_any  = 1'b0;
    hit_idx   = '0;
    hit_total = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_any   = hit_any | res[i].hit;
      miss_any  = miss_any | res[i].miss;
      hit_total = hit_total | res[i].total;
      if (res[i].hit) begin
        hit_idx = hit_idx | SEL_W'(i);
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= hit_any | miss_any;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= hit_any;
    idx_q     <= hit_idx[IDX_OUT_W-1:0];
    total_q   <= hit_total;
  end

  assign done_o        = done_q;
  assign granted_o     = granted_q;
  assign entry_index_o = idx_q;
  assign entry_total_o = total_q;

  // ---- checks ----
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token in the row");

  a_accept_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && tok_vec[0]))
    else $error("accepted request did not enter the first cell");

  a_done_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result without a finished walk");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !granted_o) |-> (entry_index_o == '0 && entry_total_o == '0))
    else $error("refused request carries index or total");

endmodule

`default_nettype wire

[sim/lowest_free_lease_allocator_top_test.sv]
`timescale 1ns / 1ps

// Testbench for the lowest-free lease allocator.
// The driver takes words from word_q at the falling edge. A word is either a
// request (start/busy handshake) or a pool-size write. Pool-size writes go
// out only while the block is idle. The monitor works at the rising edge.
// On each accepted request it runs the lease predictor and queues the
// expected word. Each done_o strobe is checked against the oldest one.
module lowest_free_lease_allocator_top_test;
  import lfla_pkg::*;

  localparam int unsigned POOL         = MAX_ENTRIES_DEF;
  localparam int          QUIET_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int          DRAIN_CYCLES = 80;    // outlasts the longest refusal walk
  localparam int          NUM_PHASES   = 12;
  localparam int          PHASE_WORDS  = 95;

  // one pending stimulus word: a request or a pool-size write
  typedef struct {
    bit                is_cfg;
    bit                calm;    // never idle in front of this word
    bit [CFG_W-1:0]    count;
    bit [TIME_W-1:0]   t;
    bit [AMOUNT_W-1:0] amt;
    bit [TIME_W-1:0]   hold;
  } word_t;

  typedef struct packed {
    bit                 granted;
    bit [IDX_OUT_W-1:0] idx;
    bit [TOTAL_W-1:0]   total;
  } lease_res_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  start           = 1'b0;
  logic [TIME_W-1:0]     request_time_i  = '0;
  logic [AMOUNT_W-1:0]   amount_i        = '0;
  logic [TIME_W-1:0]     hold_duration_i = '0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i     = CFG_RESET;
  logic                  busy;
  logic                  done_o;
  logic                  granted_o;
  logic [IDX_OUT_W-1:0]  entry_index_o;
  logic [TOTAL_W-1:0]    entry_total_o;

  word_t      word_q[$];        // stimulus not yet driven
  lease_res_t open_totals[$];   // predicted words not yet seen on done_o

  // predictor state: lease flags, release times and running totals
  bit               lease_held[POOL];
  bit [REL_W-1:0]   lease_until[POOL];
  bit [TOTAL_W-1:0] lease_sum[POOL];
  bit [CFG_W-1:0]   lease_count = CFG_RESET;

  bit took_req = 1'b0;  // request accepted at the last rising edge
  bit stalled  = 1'b0;
  int quiet    = 0;
  int faults   = 0;
  int grants_seen = 0;
  int refusals_seen = 0;
  int cfg_writes = 0;

  lowest_free_lease_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .request_time_i  (request_time_i),
    .amount_i        (amount_i),
    .hold_duration_i (hold_duration_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .granted_o       (granted_o),
    .entry_index_o   (entry_index_o),
    .entry_total_o   (entry_total_o)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  // pool size as the block sees it: 0 acts as 1, anything above the pool as the pool
  function automatic int active_of(input bit [CFG_W-1:0] count);
    if (count == 0) return 1;
    if (count > POOL) return POOL;
    return count;
  endfunction

  // expire old leases, then hand the lowest free active entry to this request
  function automatic lease_res_t grant_lowest(input bit [TIME_W-1:0] t,
                                              input bit [AMOUNT_W-1:0] amt,
                                              input bit [TIME_W-1:0] hold);
    lease_res_t r;
    int         eff;
    r   = '0;
    eff = active_of(lease_count);
    // expiry applies to every entry, also those above the active count
    for (int i = 0; i < POOL; i++)
      if (lease_held[i] && lease_until[i] <= {1'b0, t}) lease_held[i] = 1'b0;
    for (int i = 0; i < eff; i++) begin
      if (!lease_held[i]) begin
        lease_sum[i]   += amt;             // wraps mod 2^64
        lease_held[i]   = 1'b1;
        lease_until[i]  = {1'b0, t} + {1'b0, hold};  // needs the 32nd bit
        r.granted       = 1'b1;
        r.idx           = IDX_OUT_W'(i);
        r.total         = lease_sum[i];
        break;
      end
    end
    return r;
  endfunction

  task automatic queue_request(input bit [TIME_W-1:0] t, input bit [AMOUNT_W-1:0] amt,
                               input bit [TIME_W-1:0] hold, input bit calm);
    word_t w;
    w.is_cfg = 1'b0;
    w.calm   = calm;
    w.count  = '0;
    w.t      = t;
    w.amt    = amt;
    w.hold   = hold;
    word_q.push_back(w);
  endtask

  task automatic queue_size_write(input bit [CFG_W-1:0] count);
    word_t w;
    w.is_cfg = 1'b1;
    w.calm   = 1'b1;
    w.count  = count;
    w.t      = '0;
    w.amt    = '0;
    w.hold   = '0;
    word_q.push_back(w);
  endtask

  // Driver: one nonblocking update of start and cfg_we_i per falling edge, so a
  // back-to-back request keeps start high without a glitch.
  always @(negedge clk_i) begin : drive_words
    logic  nxt_start;
    logic  nxt_we;
    word_t w;
    nxt_start = start;
    nxt_we    = 1'b0;
    if (rst_ni) begin
      if (start && took_req) nxt_start = 1'b0;
      if (!nxt_start && word_q.size() != 0) begin
        w = word_q[0];
        if (w.is_cfg) begin
          // pool size only changes with nothing in flight
          if (!start && !busy && open_totals.size() == 0) begin
            nxt_we      = 1'b1;
            cfg_wdata_i <= w.count;
            void'(word_q.pop_front());
          end
        end else if (w.calm || $urandom_range(0, 99) >= 28) begin
          nxt_start       = 1'b1;
          request_time_i  <= w.t;
          amount_i        <= w.amt;
          hold_duration_i <= w.hold;
          void'(word_q.pop_front());
        end
      end
    end
    start    <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // Monitor: checks done_o words, tracks config writes, predicts accepted requests.
  always @(posedge clk_i) begin : watch_words
    lease_res_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        moved = 1'b1;
        if (granted_o === 1'b1) grants_seen++;
        else refusals_seen++;
        if (open_totals.size() == 0) begin
          faults++;
          $display("%0t: result word with none expected (granted %b index %0d total %0h)",
                   $time, granted_o, entry_index_o, entry_total_o);
        end else begin
          want = open_totals.pop_front();
          if (granted_o !== want.granted) begin
            faults++;
            $display("%0t: granted expected %b, got %b", $time, want.granted, granted_o);
          end
          if (entry_index_o !== want.idx) begin
            faults++;
            $display("%0t: entry_index expected %0d, got %0d", $time, want.idx,
                     entry_index_o);
          end
          if (entry_total_o !== want.total) begin
            faults++;
            $display("%0t: entry_total expected %0h, got %0h", $time, want.total,
                     entry_total_o);
          end
        end
      end
      if (cfg_we_i) begin
        moved       = 1'b1;
        lease_count = cfg_wdata_i;
        cfg_writes++;
      end
      if (start && !busy) begin
        moved = 1'b1;
        open_totals.push_back(grant_lowest(request_time_i, amount_i, hold_duration_i));
      end
      took_req <= start && !busy;
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) stalled = 1'b1;
    end
  end

  initial begin : run_test
    bit [CFG_W-1:0] sizes[NUM_PHASES];
    int             eff;
    int unsigned    now_t;
    int unsigned    step_hi;
    int unsigned    hold_hi;
    int unsigned    t;
    bit             calm;

    sizes = '{7'd8, 7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd17, 7'd2, 7'd40, 7'd64, 7'd5,
              7'd100};

    // --- directed: small pool, fill it, refuse, expire, resize ---
    queue_size_write(7'd4);
    queue_request(31'd0, 32'h0, 31'd0, 1'b0);          // zero amount, zero hold
    queue_request(31'd0, 32'hFFFF_FFFF, 31'd0, 1'b0);  // zero hold frees at same time
    queue_request(31'd0, 32'hFFFF_FFFF, 31'd10, 1'b0); // total crosses 32 bits
    queue_request(31'd1, 32'd1, 31'd10, 1'b0);
    queue_request(31'd1, 32'd2, 31'd10, 1'b0);
    queue_request(31'd1, 32'd3, 31'd10, 1'b0);         // pool now full
    queue_request(31'd2, 32'd4, 31'd0, 1'b0);          // refused
    queue_request(31'd10, 32'd5, 31'd1, 1'b0);         // release exactly at request time
    queue_request(31'd11, 32'd6, 31'd100, 1'b0);
    queue_request(31'd11, 32'd7, 31'd100, 1'b0);
    queue_request(31'd11, 32'd8, 31'd100, 1'b0);
    queue_request(31'd11, 32'd9, 31'd100, 1'b0);
    // shrink below busy entries: the upper ones stay leased but out of reach
    queue_size_write(7'd2);
    queue_request(31'd50, 32'hAAAA_AAAA, 31'd5, 1'b0);
    queue_size_write(7'd127);                           // saturates to the full pool
    queue_request(31'd50, 32'h5555_5555, 31'd0, 1'b0);
    queue_size_write(7'd0);                             // acts as one entry
    queue_request(31'd111, 32'h1234_5678, 31'd0, 1'b0);
    queue_request(31'd20, 32'd1, 31'd3, 1'b0);         // time steps backwards
    queue_size_write(7'd64);
    queue_request(31'd111, 32'd2, 31'd0, 1'b0);

    // --- random phases: the clock climbs through the whole time range ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      queue_size_write(sizes[p]);
      eff     = active_of(sizes[p]);
      step_hi = $urandom_range(1, 20);
      // from about half full to saturated, depending on the multiplier
      hold_hi = eff * step_hi * $urandom_range(1, 3) / 2 + 1;
      now_t   = p * 178956970 + $urandom_range(0, 1000);
      calm    = (p == 4 || p == 5);  // long stretch with no sender gaps
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 10) begin
          // out-of-order time; lease ends no later than the current clock
          t = $urandom_range(0, now_t);
          queue_request(TIME_W'(t), $urandom,
                        TIME_W'($urandom_range(0, now_t - t)), calm);
        end else begin
          now_t += $urandom_range(0, step_hi);
          queue_request(TIME_W'(now_t), $urandom,
                        TIME_W'($urandom_range(0, hold_hi)), calm);
        end
      end
    end

    // --- extremes last, since a lease ending at the top of time never frees ---
    queue_request(31'd0, 32'h5555_5555, 31'h7FFF_FFFF, 1'b0);
    queue_request(31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd0, 1'b0);
    queue_request(31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);  // release 2^32-2

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!stalled && !(word_q.size() == 0 && !start && open_totals.size() == 0))
      @(posedge clk_i);
    if (!stalled) repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (stalled) begin
      faults++;
      $display("%0t: no handshake for %0d cycles, stopping", $time, QUIET_LIMIT);
    end

    $display("%0d requests checked: %0d granted, %0d refused with the pool full",
             grants_seen + refusals_seen, grants_seen, refusals_seen);
    $display("%0d pool-size writes covering sizes 0, 1 through 64 and above 64",
             cfg_writes);
    if (faults == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lfla_pkg.sv
rtl/core/lfla_cell.sv
rtl/core/lowest_free_lease_allocator_top.sv
sim/lowest_free_lease_allocator_top_test.sv
